### src/sensor_pixel_readout_convert_assert.svh
// assertion macros shared by the checker files
`ifndef SENSOR_PIXEL_READOUT_CONVERT_ASSERT_SVH
`define SENSOR_PIXEL_READOUT_CONVERT_ASSERT_SVH

// same-cycle implication, skipped while reset is low
`define SPR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("spr check failed");

// next-cycle implication, skipped while reset is low
`define SPR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("spr check failed");

`endif

### src/spr_pkg.sv
// package: types, constants and codes of the pixel readout converter
`default_nettype none

package spr_pkg;

  localparam int unsigned ELECTRON_BITS_DEF = 16;

  localparam int unsigned SENS_W  = 11;
  localparam int unsigned SCALE_W = 8;
  localparam int unsigned RAW_W   = 13;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned OUT_W   = 56;

  localparam int unsigned SENS_RESET  = 100;
  // floor(100 * 51 / 625)
  localparam int unsigned SCALE_RESET = 8;

  // floor(s * 51 / 625) == (s * SCALE_RECIP) >> SCALE_SHIFT for any 11-bit s
  localparam int unsigned SCALE_RECIP_W = 24;
  localparam int unsigned SCALE_RECIP   = 10952199;
  localparam int unsigned SCALE_SHIFT   = 27;

  localparam int unsigned SAT_ELECTRONS = 2000;
  localparam int unsigned E_W           = 11;
  localparam int unsigned RAWX_W        = E_W + SENS_W;
  localparam int unsigned MAX_RAW       = 4000;
  localparam int unsigned BLACK_LEVEL   = 1000;
  // products at or above this give a raw count past the clamp
  localparam int unsigned RAW_SAT_X     = (MAX_RAW + 1) * 50;
  // floor(x / 50) == (x * RAW_RECIP) >> RAW_SHIFT for x below RAW_SAT_X
  localparam int unsigned RAW_X_W       = 18;
  localparam int unsigned RAW_RECIP_W   = 19;
  localparam int unsigned RAW_RECIP     = 335545;
  localparam int unsigned RAW_SHIFT     = 24;
  localparam int unsigned RAW_PROD_W    = RAW_X_W + RAW_RECIP_W;

  localparam int unsigned BYTE_LIMIT = 255 * 64;
  localparam int unsigned BYTE_SHIFT = 6;
  // average saturates once the three-channel sum reaches three byte limits
  localparam int unsigned LUMA_LIMIT  = 3 * BYTE_LIMIT;
  localparam int unsigned LUMA_IN_W   = 10;
  // floor(v / 3) == (v * LUMA_RECIP) >> LUMA_SHIFT for v below 1024
  localparam int unsigned LUMA_RECIP  = 683;
  localparam int unsigned LUMA_SHIFT  = 11;
  localparam int unsigned LUMA_PROD_W = 2 * LUMA_IN_W;

  typedef enum logic [1:0] {
    MODE_RAW  = 2'd0,
    MODE_RGB  = 2'd1,
    MODE_RGBA = 2'd2,
    MODE_LUMA = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    BAYER_R  = 2'b00,
    BAYER_GR = 2'b01,
    BAYER_GB = 2'b10,
    BAYER_B  = 2'b11
  } bayer_e;

  typedef struct packed {
    logic [SENS_W-1:0]  sens;
    logic [SCALE_W-1:0] scale;
  } gain_t;

endpackage

`default_nettype wire

### src/sensor_pixel_readout_convert.sv
// top level: four-stage pixel conversion pipeline
//
// Input stream s_axis carries one pixel per request: the four electron
// counts and the row and column parity in tdata, the conversion mode in
// tuser. Output stream m_axis carries one packed sample per pixel.
// The cfg channel writes the sensitivity; it is always ready and must only
// be written while no pixel is in flight.
// A pixel passes through the four register stages (channel select and
// colour multiply, gain multiply and byte limiting, reciprocal multiplies,
// final clamp and packing) before its result is presented. Throughput: one
// pixel per cycle unless a stalled receiver has filled the pipeline.
// Each stage has its own valid bit and moves whenever the stage after it
// is empty or moving, so a stalled receiver holds the output register and
// the pipeline fills behind it; s_axis_tready drops only once every stage
// holds a pixel. Nothing is lost or repeated across a stall.
// Reset empties the pipeline and loads sensitivity 100.
`default_nettype none

module sensor_pixel_readout_convert #(
  parameter int unsigned ELECTRON_BITS = spr_pkg::ELECTRON_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // red, green_red, green_blue, blue electrons, row_odd, column_odd, zero pad
  input  logic [((4*ELECTRON_BITS+2+7)/8)*8-1:0] s_axis_tdata,
  // action
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // raw_sample, red, green, blue, alpha, luma bytes, zero pad
  output logic [spr_pkg::OUT_W-1:0]         m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spr_pkg::SENS_W-1:0]        cfg_data_i
);

  localparam int unsigned EB    = ELECTRON_BITS;
  localparam int unsigned PRODW = EB + spr_pkg::SCALE_W;
  localparam int unsigned SUMW  = PRODW + 2;
  localparam int unsigned BW    = spr_pkg::BYTE_W;

  function automatic logic [BW-1:0] to_byte(input logic [PRODW-1:0] p);
    logic [PRODW-1:0] sh;
    sh = p >> spr_pkg::BYTE_SHIFT;
    return (p < PRODW'(spr_pkg::BYTE_LIMIT)) ? sh[BW-1:0] : {BW{1'b1}};
  endfunction

  spr_pkg::gain_t gain;

  spr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .gain_o      (gain)
  );

  // input unpacking
  logic [EB-1:0] in_red, in_gr, in_gb, in_blue;
  logic          in_row_odd, in_col_odd;
  assign in_red     = s_axis_tdata[0*EB +: EB];
  assign in_gr      = s_axis_tdata[1*EB +: EB];
  assign in_gb      = s_axis_tdata[2*EB +: EB];
  assign in_blue    = s_axis_tdata[3*EB +: EB];
  assign in_row_odd = s_axis_tdata[4*EB];
  assign in_col_odd = s_axis_tdata[4*EB+1];

  // stage handshake
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: bayer pick and clamp, colour multiplies
  spr_pkg::mode_e           mode1_q;
  logic [EB-1:0]            ch_sel;
  logic [spr_pkg::E_W-1:0]  e1_d, e1_q;
  logic [PRODW-1:0]         r1_d, g1_d, b1_d, r1_q, g1_q, b1_q;

  always_comb begin
    case (spr_pkg::bayer_e'({in_row_odd, in_col_odd}))
      spr_pkg::BAYER_R:  ch_sel = in_red;
      spr_pkg::BAYER_GR: ch_sel = in_gr;
      spr_pkg::BAYER_GB: ch_sel = in_gb;
      default:           ch_sel = in_blue;
    endcase
    e1_d = (ch_sel > EB'(spr_pkg::SAT_ELECTRONS)) ? spr_pkg::E_W'(spr_pkg::SAT_ELECTRONS)
                                                  : ch_sel[spr_pkg::E_W-1:0];
    r1_d = PRODW'(in_red)  * PRODW'(gain.scale);
    g1_d = PRODW'(in_gr)   * PRODW'(gain.scale);
    b1_d = PRODW'(in_blue) * PRODW'(gain.scale);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      mode1_q <= spr_pkg::mode_e'(s_axis_tuser);
      e1_q    <= e1_d;
      r1_q    <= r1_d;
      g1_q    <= g1_d;
      b1_q    <= b1_d;
    end
  end

  // stage 2: gain multiply for raw, byte limiting and channel sum
  spr_pkg::mode_e             mode2_q;
  logic [spr_pkg::RAWX_W-1:0] x2_d, x2_q;
  logic [BW-1:0]              rb2_q, gb2_q, bb2_q;
  logic [SUMW-1:0]            sum2_d, sum2_q;

  assign x2_d   = spr_pkg::RAWX_W'(e1_q) * spr_pkg::RAWX_W'(gain.sens);
  assign sum2_d = SUMW'(r1_q) + SUMW'(g1_q) + SUMW'(b1_q);

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      mode2_q <= mode1_q;
      x2_q    <= x2_d;
      rb2_q   <= to_byte(r1_q);
      gb2_q   <= to_byte(g1_q);
      bb2_q   <= to_byte(b1_q);
      sum2_q  <= sum2_d;
    end
  end

  // stage 3: divide by 50 and by 192 through reciprocals
  spr_pkg::mode_e                  mode3_q;
  logic                            raw_sat3_q, luma_sat3_q;
  logic [spr_pkg::RAW_PROD_W-1:0]  raw_prod3_d, raw_prod3_q;
  logic [spr_pkg::LUMA_PROD_W-1:0] luma_prod3_d, luma_prod3_q;
  logic [BW-1:0]                   rb3_q, gb3_q, bb3_q;

  assign raw_prod3_d  = spr_pkg::RAW_PROD_W'(x2_q[spr_pkg::RAW_X_W-1:0])
                      * spr_pkg::RAW_PROD_W'(spr_pkg::RAW_RECIP);
  assign luma_prod3_d = spr_pkg::LUMA_PROD_W'(
                          sum2_q[spr_pkg::BYTE_SHIFT +: spr_pkg::LUMA_IN_W])
                      * spr_pkg::LUMA_PROD_W'(spr_pkg::LUMA_RECIP);

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      mode3_q      <= mode2_q;
      raw_sat3_q   <= x2_q >= spr_pkg::RAWX_W'(spr_pkg::RAW_SAT_X);
      luma_sat3_q  <= sum2_q >= SUMW'(spr_pkg::LUMA_LIMIT);
      raw_prod3_q  <= raw_prod3_d;
      luma_prod3_q <= luma_prod3_d;
      rb3_q        <= rb2_q;
      gb3_q        <= gb2_q;
      bb3_q        <= bb2_q;
    end
  end

  // stage 4: clamp, black level, packing by mode
  logic [spr_pkg::RAW_W-1:0] raw_cnt, raw_val;
  logic [BW-1:0]             luma_val;
  logic [spr_pkg::OUT_W-1:0] out_d, out_q;

  always_comb begin
    raw_cnt  = raw_sat3_q ? spr_pkg::RAW_W'(spr_pkg::MAX_RAW)
                          : raw_prod3_q[spr_pkg::RAW_SHIFT +: spr_pkg::RAW_W];
    raw_val  = raw_cnt + spr_pkg::RAW_W'(spr_pkg::BLACK_LEVEL);
    luma_val = luma_sat3_q ? {BW{1'b1}} : luma_prod3_q[spr_pkg::LUMA_SHIFT +: BW];
    out_d    = '0;
    unique case (mode3_q)
      spr_pkg::MODE_RAW: begin
        out_d[0 +: spr_pkg::RAW_W] = raw_val;
      end
      spr_pkg::MODE_RGB: begin
        out_d[spr_pkg::RAW_W + 0*BW +: BW] = rb3_q;
        out_d[spr_pkg::RAW_W + 1*BW +: BW] = gb3_q;
        out_d[spr_pkg::RAW_W + 2*BW +: BW] = bb3_q;
      end
      spr_pkg::MODE_RGBA: begin
        out_d[spr_pkg::RAW_W + 0*BW +: BW] = rb3_q;
        out_d[spr_pkg::RAW_W + 1*BW +: BW] = gb3_q;
        out_d[spr_pkg::RAW_W + 2*BW +: BW] = bb3_q;
        out_d[spr_pkg::RAW_W + 3*BW +: BW] = {BW{1'b1}};
      end
      spr_pkg::MODE_LUMA: begin
        out_d[spr_pkg::RAW_W + 4*BW +: BW] = luma_val;
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

### src/spr_cfg.sv
// sensitivity register and derived colour scale
`default_nettype none

module spr_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [spr_pkg::SENS_W-1:0] cfg_data_i,
  output spr_pkg::gain_t             gain_o
);

  localparam int unsigned ProdW = spr_pkg::SENS_W + spr_pkg::SCALE_RECIP_W;

  logic [ProdW-1:0]            scale_prod;
  logic [spr_pkg::SENS_W-1:0]  sens_q;
  logic [spr_pkg::SCALE_W-1:0] scale_q, scale_d;

  // scale is worked out from the write data so it is ready with the register
  assign scale_prod = ProdW'(cfg_data_i) * ProdW'(spr_pkg::SCALE_RECIP);
  assign scale_d    = scale_prod[spr_pkg::SCALE_SHIFT +: spr_pkg::SCALE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q  <= spr_pkg::SENS_W'(spr_pkg::SENS_RESET);
      scale_q <= spr_pkg::SCALE_W'(spr_pkg::SCALE_RESET);
    end else if (cfg_valid_i) begin
      sens_q  <= cfg_data_i;
      scale_q <= scale_d;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign gain_o.sens  = sens_q;
  assign gain_o.scale = scale_q;

endmodule

`default_nettype wire

### src/spr_checker.sv
// port-level checks on the output stream, bound to the top level
`default_nettype none

`include "sensor_pixel_readout_convert_assert.svh"

module spr_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      m_tvalid_i,
  input  logic                      m_tready_i,
  input  logic [spr_pkg::OUT_W-1:0] m_tdata_i
);

  logic [12:0] raw;
  logic [7:0]  alpha, luma;
  logic [39:0] bytes;
  logic [31:0] rgba;

  assign raw   = m_tdata_i[12:0];
  assign bytes = m_tdata_i[52:13];
  assign rgba  = m_tdata_i[44:13];
  assign alpha = m_tdata_i[44:37];
  assign luma  = m_tdata_i[52:45];

  // a held result stays put until taken
  `SPR_ASSERT_NXT(a_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i))
  // raw samples always carry the black level and nothing else
  `SPR_ASSERT_IMP(a_raw_only, clk_i, rst_ni, m_tvalid_i && raw != 13'd0, raw >= 13'd1000 && raw <= 13'd5000 && bytes == 40'd0)
  // alpha is either off or fully opaque
  `SPR_ASSERT_IMP(a_alpha, clk_i, rst_ni, m_tvalid_i && alpha != 8'd0, alpha == 8'hff && luma == 8'd0)
  // luma mode leaves the colour bytes clear
  `SPR_ASSERT_IMP(a_luma_only, clk_i, rst_ni, m_tvalid_i && luma != 8'd0, rgba == 32'd0 && raw == 13'd0)

endmodule

bind sensor_pixel_readout_convert spr_checker u_spr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata)
);

`default_nettype wire

### dv/readout_check_pkg.sv
// pixel and sample types and the scoreboard that predicts converted samples
package readout_check_pkg;
  import spr_pkg::*;

  // total gain is sensitivity / 50; colour scale is floor(sensitivity * 51 / 625)
  localparam int unsigned GAIN_DIV    = 50;
  localparam int unsigned SCALE_MUL   = 51;
  localparam int unsigned SCALE_DIV   = 625;
  localparam int unsigned BYTE_MAX    = 255;
  localparam int unsigned REPORT_MAX  = 10;

  typedef logic [ELECTRON_BITS_DEF-1:0] count_t;

  typedef struct packed {
    mode_e  action;
    logic   column_odd;
    logic   row_odd;
    count_t blue_electrons;
    count_t green_blue_electrons;
    count_t green_red_electrons;
    count_t red_electrons;
  } pixel_t;

  // laid out as on m_axis_tdata, raw sample in the lowest bits
  typedef struct packed {
    logic [BYTE_W-1:0] luma_byte;
    logic [BYTE_W-1:0] alpha_byte;
    logic [BYTE_W-1:0] blue_byte;
    logic [BYTE_W-1:0] green_byte;
    logic [BYTE_W-1:0] red_byte;
    logic [RAW_W-1:0]  raw_sample;
  } sample_t;

  class sample_scoreboard;
    sample_t         pending_samples[$];
    longint unsigned sensitivity;
    int unsigned     failures;

    function new();
      sensitivity = SENS_RESET;
      failures = 0;
    endfunction

    function void set_sensitivity(logic [SENS_W-1:0] value);
      sensitivity = value;
    endfunction

    function int unsigned outstanding();
      return pending_samples.size();
    endfunction

    function logic [BYTE_W-1:0] byte_of(longint unsigned count64);
      if (count64 < BYTE_LIMIT) return BYTE_W'(count64 / 64);
      return BYTE_W'(BYTE_MAX);
    endfunction

    function sample_t convert_pixel(pixel_t p);
      sample_t         s;
      bayer_e          site;
      longint unsigned e, raw, scale, r, g, b;
      s = '0;
      if (p.action == MODE_RAW) begin
        site = bayer_e'({p.row_odd, p.column_odd});
        case (site)
          BAYER_R:  e = p.red_electrons;
          BAYER_GR: e = p.green_red_electrons;
          BAYER_GB: e = p.green_blue_electrons;
          default:  e = p.blue_electrons;
        endcase
        if (e > SAT_ELECTRONS) e = SAT_ELECTRONS;
        raw = (e * sensitivity) / GAIN_DIV;
        if (raw > MAX_RAW) raw = MAX_RAW;
        s.raw_sample = RAW_W'(raw + BLACK_LEVEL);
      end else begin
        scale = (sensitivity * SCALE_MUL) / SCALE_DIV;
        r = p.red_electrons * scale;
        g = p.green_red_electrons * scale;
        b = p.blue_electrons * scale;
        if (p.action == MODE_LUMA) begin
          s.luma_byte = byte_of((r + g + b) / 3);
        end else begin
          s.red_byte   = byte_of(r);
          s.green_byte = byte_of(g);
          s.blue_byte  = byte_of(b);
          if (p.action == MODE_RGBA) s.alpha_byte = BYTE_W'(BYTE_MAX);
        end
      end
      return s;
    endfunction

    function void note_pixel(pixel_t p);
      // append at the tail so results come back in request order
      pending_samples.insert(pending_samples.size(), convert_pixel(p));
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      if (pending_samples.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("unexpected sample: raw %0d r %0d g %0d b %0d a %0d y %0d",
                   got.raw_sample, got.red_byte, got.green_byte, got.blue_byte,
                   got.alpha_byte, got.luma_byte);
        return;
      end
      want = pending_samples.pop_front();
      if (want != got) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display({"sample mismatch: expected raw %0d r %0d g %0d b %0d a %0d y %0d,",
                    " got raw %0d r %0d g %0d b %0d a %0d y %0d"},
                   want.raw_sample, want.red_byte, want.green_byte, want.blue_byte,
                   want.alpha_byte, want.luma_byte,
                   got.raw_sample, got.red_byte, got.green_byte, got.blue_byte,
                   got.alpha_byte, got.luma_byte);
      end
    endfunction
  endclass

endpackage

### dv/testbench.sv
// stimulus, handshakes and run control for the pixel readout converter
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spr_pkg::*;
  import readout_check_pkg::*;

  localparam int unsigned IN_W        = ((4 * ELECTRON_BITS_DEF + 2 + 7) / 8) * 8;
  localparam int unsigned PIX_W       = 4 * ELECTRON_BITS_DEF + 2;
  localparam int unsigned SAMPLE_W    = $bits(sample_t);
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam count_t      COUNT_MAX   = '1;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [SENS_W-1:0]   cfg_data_i;

  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  sample_scoreboard    board;

  sensor_pixel_readout_convert dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // sample receiver with random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_sample(sample_t'(m_axis_tdata[SAMPLE_W-1:0]));
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // give up once nothing has moved for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("sensor_pixel_readout_convert test failed");
    $finish;
  end

  function automatic count_t random_count();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: return count_t'($urandom);
      3, 4:    return count_t'($urandom_range(0, 2100));
      5:       return count_t'($urandom_range(1990, 2010));
      6:       return count_t'($urandom_range(0, 255));
      7:       return count_t'($urandom_range(0, 31));
      8:       return ($urandom_range(0, 1) != 0) ? COUNT_MAX : count_t'(0);
      default: return count_t'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.action               = mode_e'($urandom_range(0, 3));
    p.column_odd           = 1'($urandom);
    p.row_odd              = 1'($urandom);
    p.red_electrons        = random_count();
    p.green_red_electrons  = random_count();
    p.green_blue_electrons = random_count();
    p.blue_electrons       = random_count();
    return p;
  endfunction

  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - PIX_W){1'b0}}, p.column_odd, p.row_odd, p.blue_electrons,
                      p.green_blue_electrons, p.green_red_electrons, p.red_electrons};
    s_axis_tuser  <= p.action;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_pixel(p);
  endtask

  task automatic send_directed(input mode_e action, input count_t r, input count_t gr,
                               input count_t gb, input count_t b, input logic row_odd,
                               input logic column_odd);
    pixel_t p;
    p.action               = action;
    p.row_odd              = row_odd;
    p.column_odd           = column_odd;
    p.red_electrons        = r;
    p.green_red_electrons  = gr;
    p.green_blue_electrons = gb;
    p.blue_electrons       = b;
    send_pixel(p);
  endtask

  // hold the sender until every request in flight has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_sensitivity(input logic [SENS_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    board.set_sensitivity(value);
  endtask

  initial begin
    int unsigned       phase;
    int unsigned       k;
    logic [SENS_W-1:0] sens;

    board          = new();
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = MODE_RAW;
    m_axis_tready  = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    send_idle_pct  = 22;
    recv_stall_pct = 45;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pixels at the reset sensitivity; every bayer site in raw mode
    send_directed(MODE_RAW, 100, 500, 1500, 2000, 1'b0, 1'b0);
    send_directed(MODE_RAW, 100, 500, 1500, 2000, 1'b0, 1'b1);
    send_directed(MODE_RAW, 100, 500, 1500, 2000, 1'b1, 1'b0);
    send_directed(MODE_RAW, 100, 500, 1500, 2000, 1'b1, 1'b1);
    send_directed(MODE_RAW, COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b0, 1'b0);
    send_directed(MODE_RAW, 0, 0, 0, 0, 1'b1, 1'b1);
    send_directed(MODE_RAW, 7, 9, 11, 2001, 1'b1, 1'b1);
    send_directed(MODE_RAW, 1999, 3, 5, 7, 1'b0, 1'b0);
    // colour bytes just under and at saturation with scale 8
    send_directed(MODE_RGB, 0, 0, 0, 0, 1'b0, 1'b0);
    send_directed(MODE_RGB, COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b1, 1'b1);
    send_directed(MODE_RGB, 1, 2039, 777, 2040, 1'b0, 1'b1);
    send_directed(MODE_RGB, 63, 8, 0, 7, 1'b1, 1'b0);
    send_directed(MODE_RGBA, 0, 0, 0, 0, 1'b0, 1'b0);
    send_directed(MODE_RGBA, COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b1, 1'b1);
    send_directed(MODE_RGBA, 2040, 1, 12345, 2039, 1'b1, 1'b0);
    send_directed(MODE_LUMA, 0, 0, 0, 0, 1'b0, 1'b0);
    send_directed(MODE_LUMA, COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b1, 1'b1);
    send_directed(MODE_LUMA, 2040, 2040, 0, 2040, 1'b0, 1'b1);
    send_directed(MODE_LUMA, 2039, 2040, COUNT_MAX, 2040, 1'b1, 1'b0);
    send_directed(MODE_LUMA, 6000, 0, 0, 120, 1'b0, 1'b0);
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       sens = '0;
        1:       sens = 11'd1600;
        2:       sens = 11'd1;
        3:       sens = '1;
        4:       sens = 11'd50;
        5:       sens = SENS_W'($urandom);
        default: sens = SENS_W'($urandom_range(1, 1600));
      endcase
      // receiver-heavy stalling first, then sender-heavy idling, then none
      if (phase < 3) begin
        send_idle_pct  = 22;
        recv_stall_pct = 45;
      end else if (phase < 5) begin
        send_idle_pct  = 45;
        recv_stall_pct = 22;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_sensitivity(sens);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) wait_drained();
        send_pixel(random_pixel());
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (board.failures == 0 && board.outstanding() == 0)
      $display("sensor_pixel_readout_convert test passed");
    else
      $display("sensor_pixel_readout_convert test failed");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/spr_pkg.sv
src/spr_cfg.sv
src/sensor_pixel_readout_convert.sv
src/spr_checker.sv
dv/readout_check_pkg.sv
dv/testbench.sv
